[src/dms_pkg.sv]
// Shared types and constants for the depth match scoring block.
package dms_pkg;

   localparam int DEPTH_WIDTH     = 16;
   localparam int CNT_WIDTH       = 17;
   localparam int SUM_WIDTH       = 32;
   localparam int MEAN_WIDTH      = 20;
   localparam int FRAC_BITS       = 4;
   localparam int QUOT_WIDTH      = SUM_WIDTH + FRAC_BITS;
   localparam int CSR_DATA_WIDTH  = 17;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int QUEUE_DEPTH     = 2;

   localparam int DEFAULT_MAX_PIXELS = 65536;

   localparam logic [DEPTH_WIDTH-1:0] RESET_INLIER_THRESHOLD = DEPTH_WIDTH'(50);
   localparam logic [CNT_WIDTH-1:0]   RESET_MIN_VALID_PIXELS = CNT_WIDTH'(3000);
   localparam logic [CNT_WIDTH-1:0]   RESET_MAX_OUTLIERS     = CNT_WIDTH'(100);
   localparam logic [CNT_WIDTH-1:0]   RESET_MIN_INLIERS      = CNT_WIDTH'(1000);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INLIER_THRESHOLD = 2'd0,
      CSR_MIN_VALID_PIXELS = 2'd1,
      CSR_MAX_OUTLIERS     = 2'd2,
      CSR_MIN_INLIERS      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_FINISH
   } back_state_type;

   // Per-frame totals handed from the front to the back
   typedef struct packed {
      logic [CNT_WIDTH-1:0] valid_count;
      logic [CNT_WIDTH-1:0] inlier_count;
      logic [SUM_WIDTH-1:0] difference_sum;
   } frame_summary_type;

   // Acceptance thresholds used by the back
   typedef struct packed {
      logic [CNT_WIDTH-1:0] min_valid_pixels;
      logic [CNT_WIDTH-1:0] max_outliers;
      logic [CNT_WIDTH-1:0] min_inliers;
   } accept_limits_type;

endpackage

[src/dms_front.sv]
// Pixel front end: classifies each pixel pair and accumulates per-frame totals.
module dms_front #(
   parameter int MAX_PIXELS = dms_pkg::DEFAULT_MAX_PIXELS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dms_pkg::DEPTH_WIDTH-1:0]       req_current_depth,
   input  logic [dms_pkg::DEPTH_WIDTH-1:0]       req_reference_depth,
   input  logic                                  req_last_pixel,
   input  logic [dms_pkg::DEPTH_WIDTH-1:0]       inlier_threshold,
   input  logic                                  queue_full,
   output logic                                  push_valid,
   output dms_pkg::frame_summary_type            push_summary
);

   localparam int CNT_MAX_INT = (1 << dms_pkg::CNT_WIDTH) - 1;
   localparam int CAP_INT     = (MAX_PIXELS > CNT_MAX_INT) ? CNT_MAX_INT : MAX_PIXELS;
   localparam logic [dms_pkg::CNT_WIDTH-1:0] COUNT_CAP = dms_pkg::CNT_WIDTH'(CAP_INT);

   logic [dms_pkg::CNT_WIDTH-1:0]   valid_count_ff,    valid_count_in;
   logic [dms_pkg::CNT_WIDTH-1:0]   inlier_count_ff,   inlier_count_in;
   logic [dms_pkg::SUM_WIDTH-1:0]   difference_sum_ff, difference_sum_in;
   logic [dms_pkg::CNT_WIDTH-1:0]   valid_next;
   logic [dms_pkg::CNT_WIDTH-1:0]   inlier_next;
   logic [dms_pkg::SUM_WIDTH-1:0]   sum_next;
   logic [dms_pkg::SUM_WIDTH:0]     sum_wide;
   logic [dms_pkg::DEPTH_WIDTH-1:0] difference;
   logic                            pixel_ok;
   logic                            accept;

   // Hold off only while the queue has no room for a frame summary
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Classify the pixel and form the updated totals
   always_comb begin
      pixel_ok   = (req_current_depth != '0) && (req_reference_depth != '0);
      difference = (req_current_depth >= req_reference_depth)
                   ? (req_current_depth - req_reference_depth)
                   : (req_reference_depth - req_current_depth);
      sum_wide   = {1'b0, difference_sum_ff}
                   + {{(dms_pkg::SUM_WIDTH + 1 - dms_pkg::DEPTH_WIDTH){1'b0}}, difference};
      valid_next  = valid_count_ff;
      inlier_next = inlier_count_ff;
      sum_next    = difference_sum_ff;
      if (pixel_ok) begin
         sum_next = sum_wide[dms_pkg::SUM_WIDTH] ? '1 : sum_wide[dms_pkg::SUM_WIDTH-1:0];
         if (valid_count_ff < COUNT_CAP) begin
            valid_next = valid_count_ff + 1'b1;
         end
         if ((difference < inlier_threshold) && (inlier_count_ff < COUNT_CAP)) begin
            inlier_next = inlier_count_ff + 1'b1;
         end
      end
   end

   // Advance the accumulators; clear them once the last pixel is taken
   always_comb begin
      valid_count_in    = valid_count_ff;
      inlier_count_in   = inlier_count_ff;
      difference_sum_in = difference_sum_ff;
      if (accept) begin
         if (req_last_pixel) begin
            valid_count_in    = '0;
            inlier_count_in   = '0;
            difference_sum_in = '0;
         end else begin
            valid_count_in    = valid_next;
            inlier_count_in   = inlier_next;
            difference_sum_in = sum_next;
         end
      end
   end

   assign push_valid                  = accept && req_last_pixel;
   assign push_summary.valid_count    = valid_next;
   assign push_summary.inlier_count   = inlier_next;
   assign push_summary.difference_sum = sum_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_count_ff    <= '0;
         inlier_count_ff   <= '0;
         difference_sum_ff <= '0;
      end else begin
         valid_count_ff    <= valid_count_in;
         inlier_count_ff   <= inlier_count_in;
         difference_sum_ff <= difference_sum_in;
      end
   end

endmodule

[src/dms_queue.sv]
// Short queue of frame summaries between the front and the back.
module dms_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  dms_pkg::frame_summary_type  push_summary,
   output logic                        queue_full,
   input  logic                        pop,
   output logic                        queue_empty,
   output dms_pkg::frame_summary_type  pop_summary
);

   localparam int PTR_WIDTH   = (dms_pkg::QUEUE_DEPTH > 1) ? $clog2(dms_pkg::QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(dms_pkg::QUEUE_DEPTH + 1);
   localparam logic [COUNT_WIDTH-1:0] DEPTH_COUNT = COUNT_WIDTH'(dms_pkg::QUEUE_DEPTH);
   localparam logic [PTR_WIDTH-1:0]   LAST_SLOT   = PTR_WIDTH'(dms_pkg::QUEUE_DEPTH - 1);

   dms_pkg::frame_summary_type slots_ff [dms_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] fill_ff,   fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign queue_full  = (fill_ff == DEPTH_COUNT);
   assign queue_empty = (fill_ff == '0);
   assign pop_summary = slots_ff[rd_ptr_ff];
   assign do_push     = push_valid && !queue_full;
   assign do_pop      = pop && !queue_empty;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_summary;
      end
   end

endmodule

[src/dms_back.sv]
// Frame back end: divides out the mean distance and forms the scored word.
module dms_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                queue_empty,
   input  dms_pkg::frame_summary_type          pop_summary,
   output logic                                pop,
   input  dms_pkg::accept_limits_type          limits,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dms_pkg::CNT_WIDTH-1:0]       rsp_valid_pixels,
   output logic [dms_pkg::CNT_WIDTH-1:0]       rsp_inlier_pixels,
   output logic [dms_pkg::CNT_WIDTH-1:0]       rsp_outlier_pixels,
   output logic [dms_pkg::MEAN_WIDTH-1:0]      rsp_mean_distance,
   output logic                                rsp_no_valid,
   output logic                                rsp_accepted
);

   localparam int QW        = dms_pkg::QUOT_WIDTH;
   localparam int CW        = dms_pkg::CNT_WIDTH;
   localparam int MW        = dms_pkg::MEAN_WIDTH;
   localparam int ITER_W    = $clog2(QW);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(QW - 1);

   dms_pkg::back_state_type state_ff, state_in;

   logic [CW-1:0]     divisor_ff,  divisor_in;
   logic [CW-1:0]     inlier_ff,   inlier_in;
   logic [CW-1:0]     rem_ff,      rem_in;
   logic [QW-1:0]     quot_ff,     quot_in;
   logic [ITER_W-1:0] iter_ff,     iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     valid_pix_ff,   outlier_pix_ff, inlier_pix_ff;
   logic [MW-1:0]     mean_ff;
   logic              no_valid_ff, accepted_ff;

   logic [CW:0]       shifted;
   logic              fits;
   logic              load_out;
   logic [CW-1:0]     outliers;
   logic [MW-1:0]     mean_sat;
   logic              none;
   logic              accept_ok;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dms_pkg::BACK_IDLE: begin
            if (!queue_empty) begin
               state_in = dms_pkg::BACK_DIVIDE;
            end
         end
         dms_pkg::BACK_DIVIDE: begin
            if (iter_ff == ITER_LAST) begin
               state_in = dms_pkg::BACK_FINISH;
            end
         end
         dms_pkg::BACK_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = dms_pkg::BACK_IDLE;
            end
         end
         default: state_in = dms_pkg::BACK_IDLE;
      endcase
   end

   // Control outputs of each state
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         dms_pkg::BACK_IDLE:   pop      = !queue_empty;
         dms_pkg::BACK_DIVIDE: pop      = 1'b0;
         dms_pkg::BACK_FINISH: load_out = !rsp_valid_ff || rsp_ready;
         default: begin
            pop      = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   // One restoring division step per cycle: sum * 16 / valid count
   always_comb begin
      shifted = {rem_ff, quot_ff[QW-1]};
      fits    = (shifted >= {1'b0, divisor_ff});
   end

   always_comb begin
      divisor_in = divisor_ff;
      inlier_in  = inlier_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      iter_in    = iter_ff;
      if (pop) begin
         divisor_in = pop_summary.valid_count;
         inlier_in  = pop_summary.inlier_count;
         rem_in     = '0;
         quot_in    = {pop_summary.difference_sum, {dms_pkg::FRAC_BITS{1'b0}}};
         iter_in    = '0;
      end else if (state_ff == dms_pkg::BACK_DIVIDE) begin
         rem_in  = fits ? CW'(shifted - {1'b0, divisor_ff}) : shifted[CW-1:0];
         quot_in = {quot_ff[QW-2:0], fits};
         iter_in = iter_ff + 1'b1;
      end
   end

   // Score the frame from the finished quotient
   always_comb begin
      none      = (divisor_ff == '0);
      outliers  = (inlier_ff <= divisor_ff) ? (divisor_ff - inlier_ff) : '0;
      mean_sat  = (|quot_ff[QW-1:MW]) ? '1 : quot_ff[MW-1:0];
      accept_ok = (divisor_ff >= limits.min_valid_pixels)
                  && (outliers <= limits.max_outliers)
                  && (inlier_ff >= limits.min_inliers);
   end

   // Output register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dms_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      inlier_ff  <= inlier_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      iter_ff    <= iter_in;
      if (load_out) begin
         valid_pix_ff   <= divisor_ff;
         inlier_pix_ff  <= inlier_ff;
         outlier_pix_ff <= outliers;
         mean_ff        <= none ? '0 : mean_sat;
         no_valid_ff    <= none;
         accepted_ff    <= accept_ok;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_valid_pixels   = valid_pix_ff;
   assign rsp_inlier_pixels  = inlier_pix_ff;
   assign rsp_outlier_pixels = outlier_pix_ff;
   assign rsp_mean_distance  = mean_ff;
   assign rsp_no_valid       = no_valid_ff;
   assign rsp_accepted       = accepted_ff;

endmodule

[src/depth_match_scoring.sv]
// Top level of the depth match scoring block: settings registers and wiring.
//
// Scores agreement of two depth images. The req_ channel carries one word per
// pixel pair (current and reference depth, last-pixel mark) and takes one word
// every cycle while the queue has room. A pixel counts as valid when both
// depths are nonzero; valid pixels are counted, tested against the inlier
// threshold and their absolute differences summed. The word marked last
// closes the frame: its totals go into a two-entry queue and the accumulators
// clear for the next frame. The back end takes one summary at a time and
// divides out the mean with a one-bit-per-cycle restoring divider, 36 steps.
// Each summary goes through the pop, the 36 division steps and the output
// load in turn, and the next summary is started only after that load. Frames
// that arrive faster fill the queue and the req_ channel then holds ready low
// until a slot frees.
// The rsp_ word sits in an output register until taken; a stalled receiver
// stalls the back end, then the queue, then the pixel input.
// The csr_ port writes the four thresholds, in effect from the next cycle;
// write them only while no frame is in flight. Reset clears the accumulators,
// the queue and the output, and restores the default thresholds.
module depth_match_scoring #(
   parameter int MAX_PIXELS = dms_pkg::DEFAULT_MAX_PIXELS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dms_pkg::DEPTH_WIDTH-1:0]       req_current_depth,
   input  logic [dms_pkg::DEPTH_WIDTH-1:0]       req_reference_depth,
   input  logic                                  req_last_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dms_pkg::CNT_WIDTH-1:0]         rsp_valid_pixels,
   output logic [dms_pkg::CNT_WIDTH-1:0]         rsp_inlier_pixels,
   output logic [dms_pkg::CNT_WIDTH-1:0]         rsp_outlier_pixels,
   output logic [dms_pkg::MEAN_WIDTH-1:0]        rsp_mean_distance,
   output logic                                  rsp_no_valid,
   output logic                                  rsp_accepted,
   input  logic                                  csr_write_enable,
   input  logic [dms_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dms_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   logic [dms_pkg::DEPTH_WIDTH-1:0] inlier_threshold_ff, inlier_threshold_in;
   dms_pkg::accept_limits_type      limits_ff, limits_in;
   logic                            queue_full;
   logic                            queue_empty;
   logic                            push_valid;
   logic                            pop;
   dms_pkg::frame_summary_type      push_summary;
   dms_pkg::frame_summary_type      pop_summary;

   // Decode settings writes
   always_comb begin
      inlier_threshold_in = inlier_threshold_ff;
      limits_in           = limits_ff;
      if (csr_write_enable) begin
         case (dms_pkg::csr_index_type'(csr_index))
            dms_pkg::CSR_INLIER_THRESHOLD:
               inlier_threshold_in = csr_write_data[dms_pkg::DEPTH_WIDTH-1:0];
            dms_pkg::CSR_MIN_VALID_PIXELS:
               limits_in.min_valid_pixels = csr_write_data[dms_pkg::CNT_WIDTH-1:0];
            dms_pkg::CSR_MAX_OUTLIERS:
               limits_in.max_outliers = csr_write_data[dms_pkg::CNT_WIDTH-1:0];
            dms_pkg::CSR_MIN_INLIERS:
               limits_in.min_inliers = csr_write_data[dms_pkg::CNT_WIDTH-1:0];
            default: inlier_threshold_in = inlier_threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inlier_threshold_ff        <= dms_pkg::RESET_INLIER_THRESHOLD;
         limits_ff.min_valid_pixels <= dms_pkg::RESET_MIN_VALID_PIXELS;
         limits_ff.max_outliers     <= dms_pkg::RESET_MAX_OUTLIERS;
         limits_ff.min_inliers      <= dms_pkg::RESET_MIN_INLIERS;
      end else begin
         inlier_threshold_ff <= inlier_threshold_in;
         limits_ff           <= limits_in;
      end
   end

   dms_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_current_depth   (req_current_depth),
      .req_reference_depth (req_reference_depth),
      .req_last_pixel      (req_last_pixel),
      .inlier_threshold    (inlier_threshold_ff),
      .queue_full          (queue_full),
      .push_valid          (push_valid),
      .push_summary        (push_summary)
   );

   dms_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_summary (push_summary),
      .queue_full   (queue_full),
      .pop          (pop),
      .queue_empty  (queue_empty),
      .pop_summary  (pop_summary)
   );

   dms_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (queue_empty),
      .pop_summary        (pop_summary),
      .pop                (pop),
      .limits             (limits_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_valid_pixels   (rsp_valid_pixels),
      .rsp_inlier_pixels  (rsp_inlier_pixels),
      .rsp_outlier_pixels (rsp_outlier_pixels),
      .rsp_mean_distance  (rsp_mean_distance),
      .rsp_no_valid       (rsp_no_valid),
      .rsp_accepted       (rsp_accepted)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the depth match scoring block.
module tb;
   import dms_pkg::*;

   localparam logic [CNT_WIDTH-1:0] PIXEL_CAP = (DEFAULT_MAX_PIXELS > 131071) ?
      CNT_WIDTH'(131071) : CNT_WIDTH'(DEFAULT_MAX_PIXELS);
   localparam int BIG_FRAME_WORDS = 100;
   localparam int RANDOM_WORDS    = 1300;
   localparam int TAIL_WORDS      = 280;
   localparam int DRAIN_CYCLES    = 45;
   localparam int LONG_HOLD       = 400;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0]  valid_pixels;
      logic [CNT_WIDTH-1:0]  inlier_pixels;
      logic [CNT_WIDTH-1:0]  outlier_pixels;
      logic [MEAN_WIDTH-1:0] mean_distance;
      logic                  no_valid;
      logic                  accepted;
   } frame_score_type;

   typedef struct packed {
      row_kind_type              kind;
      logic                      known;
      csr_index_type             idx;
      logic [CSR_DATA_WIDTH-1:0] data;
      logic [DEPTH_WIDTH-1:0]    cur;
      logic [DEPTH_WIDTH-1:0]    refd;
      logic                      last;
      frame_score_type           want;
   } stim_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [DEPTH_WIDTH-1:0]     req_current_depth;
   logic [DEPTH_WIDTH-1:0]     req_reference_depth;
   logic                       req_last_pixel;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [CNT_WIDTH-1:0]       rsp_valid_pixels;
   logic [CNT_WIDTH-1:0]       rsp_inlier_pixels;
   logic [CNT_WIDTH-1:0]       rsp_outlier_pixels;
   logic [MEAN_WIDTH-1:0]      rsp_mean_distance;
   logic                       rsp_no_valid;
   logic                       rsp_accepted;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   // Scoring model: thresholds and per-frame accumulators
   logic [DEPTH_WIDTH-1:0] cfg_inlier_threshold;
   logic [CNT_WIDTH-1:0]   cfg_min_valid;
   logic [CNT_WIDTH-1:0]   cfg_max_outliers;
   logic [CNT_WIDTH-1:0]   cfg_min_inliers;
   logic [CNT_WIDTH-1:0]   pix_valid_count;
   logic [CNT_WIDTH-1:0]   pix_inlier_count;
   logic [SUM_WIDTH-1:0]   pix_diff_sum;

   frame_score_type frame_scores_q [$];
   stim_row_type    dir_table [$];
   int              mismatches    = 0;
   int              words_sent    = 0;
   int              hold_requests = 0;
   bit              sender_pace   = 1'b1;
   bit              tail_calm     = 1'b0;

   depth_match_scoring u_top (.*);

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Fold one pixel pair into the frame totals; on the last pixel close the frame
   function automatic bit score_pixel(input logic [DEPTH_WIDTH-1:0] cur,
                                      input logic [DEPTH_WIDTH-1:0] refd,
                                      input logic last,
                                      output frame_score_type score);
      logic [DEPTH_WIDTH-1:0] gap;
      logic [SUM_WIDTH:0]     total;
      logic [QUOT_WIDTH-1:0]  quot;
      logic [CNT_WIDTH-1:0]   outl;
      score = '0;
      if (cur != 0 && refd != 0) begin
         gap   = (cur >= refd) ? cur - refd : refd - cur;
         total = {1'b0, pix_diff_sum} + {{(SUM_WIDTH + 1 - DEPTH_WIDTH){1'b0}}, gap};
         pix_diff_sum = total[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : total[SUM_WIDTH-1:0];
         if (pix_valid_count < PIXEL_CAP)
            pix_valid_count++;
         if (gap < cfg_inlier_threshold && pix_inlier_count < PIXEL_CAP)
            pix_inlier_count++;
      end
      if (!last)
         return 1'b0;
      outl = (pix_inlier_count <= pix_valid_count) ? pix_valid_count - pix_inlier_count : '0;
      score.valid_pixels   = pix_valid_count;
      score.inlier_pixels  = pix_inlier_count;
      score.outlier_pixels = outl;
      score.no_valid       = (pix_valid_count == 0);
      if (pix_valid_count != 0) begin
         quot = {pix_diff_sum, {FRAC_BITS{1'b0}}} / QUOT_WIDTH'(pix_valid_count);
         score.mean_distance = (quot > QUOT_WIDTH'(20'hFFFFF)) ? 20'hFFFFF
                                                               : quot[MEAN_WIDTH-1:0];
      end
      score.accepted = (pix_valid_count >= cfg_min_valid) && (outl <= cfg_max_outliers) &&
                       (pix_inlier_count >= cfg_min_inliers);
      pix_valid_count  = '0;
      pix_inlier_count = '0;
      pix_diff_sum     = '0;
      return 1'b1;
   endfunction

   // Table rows
   function automatic stim_row_type pixel_row(input logic [DEPTH_WIDTH-1:0] cur,
                                              input logic [DEPTH_WIDTH-1:0] refd,
                                              input logic last);
      stim_row_type r;
      r      = '0;
      r.kind = ROW_WORD;
      r.cur  = cur;
      r.refd = refd;
      r.last = last;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [DEPTH_WIDTH-1:0] cur,
                                              input logic [DEPTH_WIDTH-1:0] refd,
                                              input int v, input int inl, input int outl,
                                              input int mean, input bit nv, input bit acc);
      stim_row_type r;
      r       = pixel_row(cur, refd, 1'b1);
      r.known = 1'b1;
      r.want  = '{CNT_WIDTH'(v), CNT_WIDTH'(inl), CNT_WIDTH'(outl),
                  MEAN_WIDTH'(mean), nv, acc};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type idx,
                                            input logic [CSR_DATA_WIDTH-1:0] data);
      stim_row_type r;
      r      = '0;
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   // Random depth, weighted towards zero and the extremes
   function automatic logic [DEPTH_WIDTH-1:0] pick_depth();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return 16'h0001;
         default: return DEPTH_WIDTH'($urandom);
      endcase
   endfunction

   // Depth close to base, so that the difference straddles the inlier threshold
   function automatic logic [DEPTH_WIDTH-1:0] near_depth(input logic [DEPTH_WIDTH-1:0] base);
      int span;
      int val;
      span = (cfg_inlier_threshold > 1000) ? 1000 : int'(cfg_inlier_threshold) + 2;
      val  = int'(base) + int'($urandom_range(0, 2 * span)) - span;
      if (val < 1)
         val = 1;
      if (val > 65535)
         val = 65535;
      return val[DEPTH_WIDTH-1:0];
   endfunction

   // Offer one word, hold it until taken, then predict and maybe idle
   task automatic send_pixel(input logic [DEPTH_WIDTH-1:0] cur,
                             input logic [DEPTH_WIDTH-1:0] refd,
                             input logic last, input logic known,
                             input frame_score_type want);
      frame_score_type predicted;
      req_valid           <= 1'b1;
      req_current_depth   <= cur;
      req_reference_depth <= refd;
      req_last_pixel      <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
      if (score_pixel(cur, refd, last, predicted))
         frame_scores_q = {frame_scores_q, (known ? want : predicted)};
      if (sender_pace && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic send_frame(input int len);
      logic [DEPTH_WIDTH-1:0] cur;
      logic [DEPTH_WIDTH-1:0] refd;
      for (int k = 0; k < len; k++) begin
         refd = pick_depth();
         cur  = (refd != 0 && $urandom_range(0, 2) != 0) ? near_depth(refd) : pick_depth();
         send_pixel(cur, refd, k == len - 1, 1'b0, '0);
      end
   endtask

   // Drop valid and wait until every frame score has come back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (frame_scores_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_INLIER_THRESHOLD: cfg_inlier_threshold = data[DEPTH_WIDTH-1:0];
         CSR_MIN_VALID_PIXELS: cfg_min_valid        = data;
         CSR_MAX_OUTLIERS:     cfg_max_outliers     = data;
         CSR_MIN_INLIERS:      cfg_min_inliers      = data;
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // Pick a new set of thresholds, mostly small enough that short frames can be accepted
   task automatic configure_random();
      logic [CSR_DATA_WIDTH-1:0] data;
      settle();
      case ($urandom_range(0, 5))
         0:       data = '0;
         1:       data = 17'd1;
         2:       data = 17'h0FFFF;
         3:       data = CSR_DATA_WIDTH'($urandom);
         default: data = CSR_DATA_WIDTH'($urandom_range(2, 400));
      endcase
      write_reg(CSR_INLIER_THRESHOLD, data);
      case ($urandom_range(0, 5))
         0:       data = '0;
         1:       data = 17'd65536;
         2:       data = 17'h1FFFF;
         default: data = CSR_DATA_WIDTH'($urandom_range(0, 24));
      endcase
      write_reg(CSR_MIN_VALID_PIXELS, data);
      case ($urandom_range(0, 4))
         0:       data = '0;
         1:       data = 17'h1FFFF;
         default: data = CSR_DATA_WIDTH'($urandom_range(0, 12));
      endcase
      write_reg(CSR_MAX_OUTLIERS, data);
      case ($urandom_range(0, 4))
         0:       data = '0;
         1:       data = 17'd65536;
         default: data = CSR_DATA_WIDTH'($urandom_range(0, 16));
      endcase
      write_reg(CSR_MIN_INLIERS, data);
   endtask

   task automatic compare_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Result side: check each word taken, stall in random bursts and on request
   initial begin : score_sink
      frame_score_type want;
      int              hold_left;
      int              stretch_left;
      int              holds_seen;
      bit              choppy;
      hold_left    = 0;
      stretch_left = 0;
      holds_seen   = 0;
      choppy       = 1'b0;
      rsp_ready   <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (frame_scores_q.size() == 0) begin
               $display("%0t: frame score with none expected: valid %0d inlier %0d mean %0d",
                        $time, rsp_valid_pixels, rsp_inlier_pixels, rsp_mean_distance);
               mismatches++;
            end else begin
               want = frame_scores_q.pop_front();
               compare_field("valid_pixels", int'(want.valid_pixels),
                             int'(rsp_valid_pixels));
               compare_field("inlier_pixels", int'(want.inlier_pixels),
                             int'(rsp_inlier_pixels));
               compare_field("outlier_pixels", int'(want.outlier_pixels),
                             int'(rsp_outlier_pixels));
               compare_field("mean_distance", int'(want.mean_distance),
                             int'(rsp_mean_distance));
               compare_field("no_valid", int'(want.no_valid), int'(rsp_no_valid));
               compare_field("accepted", int'(want.accepted), int'(rsp_accepted));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_seen != hold_requests) begin
            holds_seen++;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(20, 200);
               choppy       = $urandom_range(0, 2) != 0;
            end
            stretch_left--;
            if (choppy && !tail_calm && $urandom_range(0, 4) == 0) begin
               hold_left = $urandom_range(0, 10);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : run_limit
      #2_000_000;
      $display("timeout with %0d frame scores outstanding", frame_scores_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus
   initial begin : pixel_source
      int start_words;
      int len;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_current_depth   <= '0;
      req_reference_depth <= '0;
      req_last_pixel      <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_index           <= '0;
      csr_write_data      <= '0;
      cfg_inlier_threshold = RESET_INLIER_THRESHOLD;
      cfg_min_valid        = RESET_MIN_VALID_PIXELS;
      cfg_max_outliers     = RESET_MAX_OUTLIERS;
      cfg_min_inliers      = RESET_MIN_INLIERS;
      pix_valid_count      = '0;
      pix_inlier_count     = '0;
      pix_diff_sum         = '0;

      dir_table = '{
         // empty frame under the reset thresholds
         known_row(16'd0, 16'd0, 0, 0, 0, 0, 1'b1, 1'b0),
         // a zero on either side makes the pixel invalid
         pixel_row(16'd100, 16'd0, 1'b0),
         pixel_row(16'd0, 16'd200, 1'b0),
         known_row(16'd5, 16'd5, 1, 1, 0, 0, 1'b0, 1'b0),
         // widest differences both ways
         pixel_row(16'hFFFF, 16'd1, 1'b0),
         known_row(16'd1, 16'hFFFF, 2, 0, 2, 1048544, 1'b0, 1'b0),
         // just under, at and over the inlier threshold
         pixel_row(16'd1049, 16'd1000, 1'b0),
         pixel_row(16'd1050, 16'd1000, 1'b0),
         known_row(16'd1000, 16'd1051, 3, 1, 2, 800, 1'b0, 1'b0),
         // mean truncates towards zero
         pixel_row(16'd2, 16'd1, 1'b0),
         pixel_row(16'd3, 16'd3, 1'b0),
         known_row(16'd4, 16'd4, 3, 3, 0, 5, 1'b0, 1'b0),
         known_row(16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 1'b0, 1'b0),
         known_row(16'd0, 16'hFFFF, 0, 0, 0, 0, 1'b1, 1'b0),
         pixel_row(16'hA5A5, 16'h5A5A, 1'b0),
         pixel_row(16'h1234, 16'h1200, 1'b0),
         pixel_row(16'h8000, 16'h7FFF, 1'b1),
         // loosest thresholds; an over-wide threshold keeps its low bits
         csr_row(CSR_MIN_VALID_PIXELS, 17'd0),
         csr_row(CSR_MAX_OUTLIERS, 17'h1FFFF),
         csr_row(CSR_MIN_INLIERS, 17'd0),
         csr_row(CSR_INLIER_THRESHOLD, 17'h1FFFF),
         known_row(16'hFFFF, 16'd1, 1, 1, 0, 1048544, 1'b0, 1'b1),
         known_row(16'd0, 16'd0, 0, 0, 0, 0, 1'b1, 1'b1),
         // zero threshold: nothing is an inlier
         csr_row(CSR_INLIER_THRESHOLD, 17'd0),
         csr_row(CSR_MAX_OUTLIERS, 17'd0),
         known_row(16'd5, 16'd5, 1, 0, 1, 0, 1'b0, 1'b0)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CSR) begin
            settle();
            write_reg(dir_table[i].idx, dir_table[i].data);
         end else begin
            send_pixel(dir_table[i].cur, dir_table[i].refd, dir_table[i].last,
                       dir_table[i].known, dir_table[i].want);
         end
      end

      // Hold off the receiver while tiny frames keep coming, so the input backs up
      configure_random();
      sender_pace = 1'b0;
      hold_requests++;
      repeat (50) send_frame($urandom_range(1, 3));
      sender_pace = 1'b1;

      // One long frame of the widest differences, every pixel an inlier
      settle();
      write_reg(CSR_INLIER_THRESHOLD, 17'h0FFFF);
      write_reg(CSR_MIN_VALID_PIXELS, 17'd100);
      write_reg(CSR_MAX_OUTLIERS, 17'd0);
      write_reg(CSR_MIN_INLIERS, 17'd100);
      sender_pace = 1'b0;
      for (int k = 0; k < BIG_FRAME_WORDS; k++)
         send_pixel(16'hFFFF, 16'h0001, k == BIG_FRAME_WORDS - 1, 1'b0, '0);

      // Random frames under a range of thresholds
      start_words = words_sent;
      while (words_sent - start_words < RANDOM_WORDS) begin
         configure_random();
         repeat ($urandom_range(3, 10)) begin
            len         = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            sender_pace = $urandom_range(0, 3) != 0;
            send_frame(len);
         end
      end

      // Closing stretch at full rate on both sides
      configure_random();
      tail_calm   = 1'b1;
      sender_pace = 1'b0;
      start_words = words_sent;
      while (words_sent - start_words < TAIL_WORDS)
         send_frame($urandom_range(1, 40));

      settle();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
